// ----- rtl/ps2lb_pkg.sv -----
package ps2lb_pkg;

  localparam int RING_DEPTH_DEF = 256;

  localparam logic [7:0] LSHIFT_DOWN = 8'd42;
  localparam logic [7:0] RSHIFT_DOWN = 8'd54;
  localparam logic [7:0] LSHIFT_UP   = 8'd170;
  localparam logic [7:0] RSHIFT_UP   = 8'd182;
  localparam logic [6:0] ASCII_BS    = 7'h08;
  localparam logic [6:0] ASCII_NUL   = 7'h00;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_READ,
    OP_ERASE,
    OP_PUSH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] ch;
  } cmd_t;

  // {plain, shifted} character for a make code
  function automatic logic [13:0] key_pair(input logic [6:0] code);
    logic [13:0] pair;
    pair = 14'h0;
    case (code)
      7'd1:  pair = {7'h1B, 7'h1B};
      7'd2:  pair = {7'h31, 7'h21};
      7'd3:  pair = {7'h32, 7'h40};
      7'd4:  pair = {7'h33, 7'h23};
      7'd5:  pair = {7'h34, 7'h24};
      7'd6:  pair = {7'h35, 7'h25};
      7'd7:  pair = {7'h36, 7'h5E};
      7'd8:  pair = {7'h37, 7'h26};
      7'd9:  pair = {7'h38, 7'h2A};
      7'd10: pair = {7'h39, 7'h28};
      7'd11: pair = {7'h30, 7'h29};
      7'd12: pair = {7'h2D, 7'h5F};
      7'd13: pair = {7'h3D, 7'h2B};
      7'd14: pair = {7'h08, 7'h08};
      7'd15: pair = {7'h09, 7'h09};
      7'd16: pair = {7'h71, 7'h51};
      7'd17: pair = {7'h77, 7'h57};
      7'd18: pair = {7'h65, 7'h45};
      7'd19: pair = {7'h72, 7'h52};
      7'd20: pair = {7'h74, 7'h54};
      7'd21: pair = {7'h79, 7'h59};
      7'd22: pair = {7'h75, 7'h55};
      7'd23: pair = {7'h69, 7'h49};
      7'd24: pair = {7'h6F, 7'h4F};
      7'd25: pair = {7'h70, 7'h50};
      7'd26: pair = {7'h5B, 7'h7B};
      7'd27: pair = {7'h5D, 7'h7D};
      7'd28: pair = {7'h0A, 7'h0A};
      7'd30: pair = {7'h61, 7'h41};
      7'd31: pair = {7'h73, 7'h53};
      7'd32: pair = {7'h64, 7'h44};
      7'd33: pair = {7'h66, 7'h46};
      7'd34: pair = {7'h67, 7'h47};
      7'd35: pair = {7'h68, 7'h48};
      7'd36: pair = {7'h6A, 7'h4A};
      7'd37: pair = {7'h6B, 7'h4B};
      7'd38: pair = {7'h6C, 7'h4C};
      7'd39: pair = {7'h3B, 7'h3A};
      7'd40: pair = {7'h27, 7'h22};
      7'd41: pair = {7'h60, 7'h7E};
      7'd43: pair = {7'h5C, 7'h7C};
      7'd44: pair = {7'h7A, 7'h5A};
      7'd45: pair = {7'h78, 7'h58};
      7'd46: pair = {7'h63, 7'h43};
      7'd47: pair = {7'h76, 7'h56};
      7'd48: pair = {7'h62, 7'h42};
      7'd49: pair = {7'h6E, 7'h4E};
      7'd50: pair = {7'h6D, 7'h4D};
      7'd51: pair = {7'h2C, 7'h3C};
      7'd52: pair = {7'h2E, 7'h3E};
      7'd53: pair = {7'h2F, 7'h3F};
      7'd55: pair = {7'h2A, 7'h2A};
      7'd57: pair = {7'h20, 7'h20};
      default: pair = 14'h0;
    endcase
    return pair;
  endfunction

endpackage

// ----- rtl/ps2_scancode_line_buffer_top.sv -----
// path: an input transfer is written into a command queue slot, then popped into the back-end output registers
// throughput: one item per cycle while the output is not stalled, set by the ring update in the back end
// a full 2-entry command queue or a stalled output register holds off input
// reset: synchronous, clears shift flag, ring pointers, fill count and queue;
// ring contents are left as they are and need no clearing pass
module ps2_scancode_line_buffer_top #(
  parameter int RING_DEPTH = ps2lb_pkg::RING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] scancode,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] read_char,
  output logic [6:0] echo_code,
  output logic       echo_erase,
  output logic       dropped,
  output logic [7:0] fill_level
);
  import ps2lb_pkg::*;

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  ps2lb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .scancode (scancode),
    .push     (push),
    .cmd      (push_cmd),
    .q_full   (q_full)
  );

  ps2lb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  ps2lb_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .cmd        (pop_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_char  (read_char),
    .echo_code  (echo_code),
    .echo_erase (echo_erase),
    .dropped    (dropped),
    .fill_level (fill_level)
  );

endmodule

// ----- rtl/ps2lb_front.sv -----
module ps2lb_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             kind,
  input  logic [7:0]       scancode,
  output logic             push,
  output ps2lb_pkg::cmd_t  cmd,
  input  logic             q_full
);
  import ps2lb_pkg::*;

  logic        shift_held;
  logic        shift_held_next;
  logic [13:0] pair;
  logic [6:0]  ch;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign pair     = key_pair(scancode[6:0]);
  assign ch       = shift_held ? pair[6:0] : pair[13:7];

  always_comb begin
    shift_held_next = shift_held;
    cmd.op          = OP_NONE;
    cmd.ch          = ch;
    if (kind) begin
      cmd.op = OP_READ;
    end else if (scancode[7]) begin
      if (scancode == LSHIFT_UP || scancode == RSHIFT_UP) begin
        shift_held_next = 1'b0;
      end
    end else if (scancode == LSHIFT_DOWN || scancode == RSHIFT_DOWN) begin
      shift_held_next = 1'b1;
    end else if (ch == ASCII_BS) begin
      cmd.op = OP_ERASE;
    end else if (ch != ASCII_NUL) begin
      cmd.op = OP_PUSH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
    end else if (push) begin
      shift_held <= shift_held_next;
    end
  end

endmodule

// ----- rtl/ps2lb_queue.sv -----
module ps2lb_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ps2lb_pkg::cmd_t  push_cmd,
  output logic             full,
  input  logic             pop,
  output ps2lb_pkg::cmd_t  pop_cmd,
  output logic             empty
);
  import ps2lb_pkg::*;

  cmd_t       slots [2];
  logic       wr_idx;
  logic       rd_idx;
  logic [1:0] level;

  assign full    = (level == 2'd2);
  assign empty   = (level == 2'd0);
  assign pop_cmd = slots[rd_idx];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_idx <= !wr_idx;
      end
      if (pop) begin
        rd_idx <= !rd_idx;
      end
      case ({push, pop})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

endmodule

// ----- rtl/ps2lb_back.sv -----
module ps2lb_back #(
  parameter int RING_DEPTH = ps2lb_pkg::RING_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  ps2lb_pkg::cmd_t  cmd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [6:0]       read_char,
  output logic [6:0]       echo_code,
  output logic             echo_erase,
  output logic             dropped,
  output logic [7:0]       fill_level
);
  import ps2lb_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_DEPTH - 1);

  logic [6:0]       char_ring [RING_DEPTH];
  logic [PTR_W-1:0] write_pointer;
  logic [PTR_W-1:0] write_pointer_next;
  logic [PTR_W-1:0] read_pointer;
  logic [PTR_W-1:0] read_pointer_next;
  logic [PTR_W-1:0] count;
  logic [PTR_W-1:0] count_next;
  logic [6:0]       rd_data;
  logic             rd_hit;
  logic             rd_hit_next;
  logic [6:0]       echo_next;
  logic             erase_next;
  logic             drop_next;
  logic             ring_we;

  assign pop       = !q_empty && (!out_valid || !out_stall);
  assign read_char = rd_hit ? rd_data : ASCII_NUL;

  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    count_next         = count;
    rd_hit_next        = 1'b0;
    echo_next          = ASCII_NUL;
    erase_next         = 1'b0;
    drop_next          = 1'b0;
    ring_we            = 1'b0;
    case (cmd.op)
      OP_READ: begin
        if (count != '0) begin
          rd_hit_next       = 1'b1;
          read_pointer_next = (read_pointer == LAST) ? '0 : read_pointer + 1'b1;
          count_next        = count - 1'b1;
        end
      end
      OP_ERASE: begin
        erase_next = 1'b1;
        if (count != '0) begin
          write_pointer_next = (write_pointer == '0) ? LAST : write_pointer - 1'b1;
          count_next         = count - 1'b1;
        end
      end
      OP_PUSH: begin
        if (count == LAST) begin
          drop_next = 1'b1;
        end else begin
          echo_next          = cmd.ch;
          ring_we            = 1'b1;
          write_pointer_next = (write_pointer == LAST) ? '0 : write_pointer + 1'b1;
          count_next         = count + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ring storage, registered read
  always_ff @(posedge clk) begin
    if (pop && ring_we) begin
      char_ring[write_pointer] <= cmd.ch;
    end
    if (pop) begin
      rd_data <= char_ring[read_pointer];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      count         <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        write_pointer <= write_pointer_next;
        read_pointer  <= read_pointer_next;
        count         <= count_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_hit     <= rd_hit_next;
      echo_code  <= echo_next;
      echo_erase <= erase_next;
      dropped    <= drop_next;
      fill_level <= 8'(count_next);
    end
  end

endmodule
